// ===== rtl/core/multi_stack_shared_array_macros.svh =====
// Assertion macros shared by the shared-array stack RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef MULTI_STACK_SHARED_ARRAY_MACROS_SVH
`define MULTI_STACK_SHARED_ARRAY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mssa_pkg.sv =====
// Package for the shared-array stack block: sizes, codes and shared types.
// No dependencies.
package mssa_pkg;

  localparam int MSSA_STORE_DEPTH = 32;
  localparam int MSSA_MAX_STACKS  = 8;

  localparam int DATA_W      = 32;
  localparam int STACK_NUM_W = 3;
  localparam int CAP_W       = 6;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT    = 2'd1;

  localparam logic [CAP_W-1:0] TOTAL_CAPACITY_RST = 6'd32;
  localparam logic [CNT_W-1:0] STACK_COUNT_RST    = 4'd8;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } mssa_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mssa_div_stat_t;

endpackage

// ===== rtl/core/mssa_ram.sv =====
// Generic single-port synchronous RAM, read-first, registered read data.
// No dependencies.
module mssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/mssa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the segment size.
// Depends on mssa_pkg for the status struct.
module mssa_div import mssa_pkg::*; #(
  parameter int DW = 6,
  parameter int VW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [VW-1:0]  divisor,
  output logic [DW-1:0]  quotient,
  output mssa_div_stat_t stat
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            ge;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out of the quotient register as quotient bits come in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/multi_stack_shared_array.sv =====
// Several stacks in fixed equal segments of one element RAM; fill counts in a second RAM.
// Push, full, empty and invalid words strobe after the execute state; a pop hit after execute and pop.
// A new word is taken in the idle or pop state but not during execute, where the fill count write-back completes.
// Reset clears fill counts and sets config to its defaults; busy then stays high
// while the divider computes the segment size; each write to a config register does the same.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
module multi_stack_shared_array import mssa_pkg::*; #(
  parameter int STORE_DEPTH = MSSA_STORE_DEPTH,
  parameter int MAX_STACKS  = MSSA_MAX_STACKS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [STACK_NUM_W-1:0]  in_stack_number,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                    out_valid,
  output logic signed [DATA_W-1:0] out_pop_value,
  output logic [1:0]              out_status,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  `include "multi_stack_shared_array_macros.svh"

  localparam int CW  = $clog2(STORE_DEPTH + 1);
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int SW  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int LCW = $clog2(MAX_STACKS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CAP_W-1:0]       total_capacity_r;
  logic [CNT_W-1:0]       stack_count_r;
  logic                   div_start_r;
  logic [CW-1:0]          seg_r;
  logic [(2**SW)-1:0]     fill_vld_r;

  logic                   mode_r;
  logic [SW-1:0]          sidx_r;
  logic [DATA_W-1:0]      push_value_r;
  logic [CW-1:0]          base_r;
  logic                   invalid_r;
  logic                   fill_hit_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]      out_pop_value_r, out_pop_value_nxt;
  mssa_status_t           out_status_r, out_status_nxt;

  logic                   accept;
  logic                   cfg_hit;
  logic [CW-1:0]          cap;
  logic [LCW-1:0]         live;
  logic [SW-1:0]          sidx_in;

  mssa_div_stat_t         div_stat;
  logic [CW-1:0]          div_quotient;

  logic [SW-1:0]          fill_addr;
  logic                   fill_we;
  logic [CW-1:0]          fill_wdata;
  logic [CW-1:0]          fill_rdata;
  logic [CW-1:0]          fill;
  logic                   elem_we;
  logic [AW-1:0]          elem_addr;
  logic [DATA_W-1:0]      elem_rdata;
  logic [AW-1:0]          pos_push;
  logic [AW-1:0]          pos_pop;

  assign cfg_hit = cfg_we && (cfg_index == REG_TOTAL_CAPACITY || cfg_index == REG_STACK_COUNT);
  assign busy    = (state_r == S_EXEC) || div_start_r || div_stat.busy || div_stat.done;
  assign accept  = start && !busy;
  assign sidx_in = SW'(in_stack_number);

  // clip configuration to what the store and the stack table hold
  assign cap  = (total_capacity_r > STORE_DEPTH) ? CW'(STORE_DEPTH) : CW'(total_capacity_r);
  assign live = (stack_count_r > MAX_STACKS) ? LCW'(MAX_STACKS) : LCW'(stack_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_capacity_r <= TOTAL_CAPACITY_RST;
      stack_count_r    <= STACK_COUNT_RST;
      div_start_r      <= 1'b1;
      fill_vld_r       <= '0;
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_TOTAL_CAPACITY) begin
        total_capacity_r <= cfg_wdata[CAP_W-1:0];
      end
      if (cfg_we && cfg_index == REG_STACK_COUNT) begin
        stack_count_r <= cfg_wdata[CNT_W-1:0];
      end
      div_start_r <= cfg_hit;
      // a repartition empties every stack
      if (cfg_hit) begin
        fill_vld_r <= '0;
      end else if (fill_we) begin
        fill_vld_r[sidx_r] <= 1'b1;
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  mssa_div #(
    .DW(CW),
    .VW(LCW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (cap),
    .divisor  (live),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (div_stat.done) begin
      seg_r <= (live == '0) ? '0 : div_quotient;
    end
    if (accept) begin
      mode_r       <= in_mode;
      sidx_r       <= sidx_in;
      push_value_r <= in_push_value;
      base_r       <= CW'(seg_r * in_stack_number);
      invalid_r    <= int'(in_stack_number) >= int'(live);
      fill_hit_r   <= fill_vld_r[sidx_in];
    end
    out_pop_value_r <= out_pop_value_nxt;
    out_status_r    <= out_status_nxt;
  end

  // fill count RAM: read at accept, written back in the execute cycle
  assign fill_addr = (state_r == S_EXEC) ? sidx_r : sidx_in;

  mssa_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_STACKS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .addr  (fill_addr),
    .wdata (fill_wdata),
    .rdata (fill_rdata)
  );

  mssa_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .addr  (elem_addr),
    .wdata (push_value_r),
    .rdata (elem_rdata)
  );

  assign fill     = fill_hit_r ? fill_rdata : '0;
  assign pos_push = AW'(base_r + fill);
  assign pos_pop  = AW'(base_r + fill - CW'(1));

  always_comb begin
    state_nxt         = state_r;
    out_valid_nxt     = 1'b0;
    out_pop_value_nxt = out_pop_value_r;
    out_status_nxt    = out_status_r;
    fill_we           = 1'b0;
    fill_wdata        = fill + CW'(1);
    elem_we           = 1'b0;
    elem_addr         = pos_push;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt         = S_IDLE;
        out_valid_nxt     = 1'b1;
        out_pop_value_nxt = '0;
        out_status_nxt    = ST_OK;
        if (invalid_r) begin
          out_status_nxt = ST_INVALID;
        end else if (mode_r == MODE_PUSH) begin
          if (fill >= seg_r) begin
            out_status_nxt = ST_FULL;
          end else begin
            elem_we = 1'b1;
            fill_we = 1'b1;
          end
        end else if (fill == '0) begin
          out_status_nxt    = ST_EMPTY;
          out_pop_value_nxt = '1;
        end else begin
          // hold the result until the element read returns
          elem_addr     = pos_pop;
          fill_we       = 1'b1;
          fill_wdata    = fill - CW'(1);
          out_valid_nxt = 1'b0;
          state_nxt     = S_POP;
        end
      end
      S_POP: begin
        out_valid_nxt     = 1'b1;
        out_pop_value_nxt = elem_rdata;
        out_status_nxt    = ST_OK;
        state_nxt         = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;

  `MSSA_ASSERT_NXT(a_accept_to_exec, accept, state_r == S_EXEC, "accept did not enter execute")
  `MSSA_ASSERT_NXT(a_exec_one, state_r == S_EXEC, out_valid_r != (state_r == S_POP), "no word")
  `MSSA_ASSERT_NXT(a_pop_out, state_r == S_POP, out_valid_r && out_status_r == ST_OK, "pop lost")
  `MSSA_ASSERT_IMP(a_fill_bound, fill_we, fill_wdata <= seg_r, "fill count beyond segment")
  `MSSA_ASSERT_IMP(a_invalid_quiet, invalid_r, !fill_we && !elem_we, "invalid stack wrote")

endmodule
